FILE: hdl/sfc_pkg.sv
`default_nettype none

package sfc_pkg;

  // Widths of the sample and coefficient fields.
  localparam int SAMPLE_WIDTH = 24;
  localparam int COEFF_WIDTH  = 18;
  localparam int COEFF_FRAC   = COEFF_WIDTH - 2;
  localparam int GUARD        = (COEFF_WIDTH > 28) ? (COEFF_WIDTH - 28) : 0;
  localparam int BQ_SHIFT     = COEFF_FRAC - GUARD;
  localparam int INT_FRAC     = 24;

  // Configuration port.
  localparam int CFG_W     = 3 * COEFF_WIDTH;
  localparam int CFG_IDX_W = 3;
  localparam int WET_W     = 18;
  localparam logic [CFG_W-1:0] COEFF_MASK =
    (CFG_W > 64) ? CFG_W'({64{1'b1}}) : {CFG_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_STAGE_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FINAL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WET     = 3'd4;

  // Stage codes.
  localparam logic [1:0] STG_A = 2'd0;
  localparam logic [1:0] STG_B = 2'd1;
  localparam logic [1:0] STG_C = 2'd2;
  localparam logic [1:0] STG_D = 2'd3;

  // Amounts are Q1.16, 0 .. 1.0.
  localparam int AMT_W = 17;
  localparam logic [AMT_W-1:0] AMT_ONE = 17'd65536;

  // Shared multiplier and accumulator.
  localparam int MA_W  = 33;
  localparam int MB_W  = (COEFF_WIDTH > 31) ? COEFF_WIDTH : 31;
  localparam int P_W   = MA_W + MB_W;
  localparam int ACC_W = P_W + 3;
  localparam logic signed [MB_W-1:0] LN10_Q28 = MB_W'(618095479);

  // State memory: biquad history at 0..31, slew memory from 32.
  localparam int ADDR_W    = 6;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  typedef enum logic [2:0] {
    OP_B0X, OP_HB0, OP_HA1, OP_HA2, OP_SLEW, OP_WET, OP_DRY
  } mul_op_e;

  typedef enum logic [1:0] {ACC_LOAD, ACC_ADD, ACC_ADD2, ACC_SUB} acc_mode_e;

  typedef enum logic [1:0] {WR_HOLD0, WR_X, WR_HOLD2, WR_Y} wr_sel_e;

  typedef struct packed {
    logic              in_load;
    logic              x_load;
    logic              ch;
    logic [1:0]        stage;
    logic              mul_en;
    mul_op_e           mul_op;
    logic              acc_en;
    acc_mode_e         acc_mode;
    logic              guard;
    logic              hold0_en;
    logic              hold2_en;
    logic              y_en;
    logic              slew_en;
    logic              x_en;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    wr_sel_e           wr_sel;
    logic              lft_en;
    logic              out_load;
  } sfc_cmd_t;

  typedef struct packed {
    logic a_nz;
    logic b_nz;
    logic c_nz;
  } sfc_sts_t;

  // Saturate a wide value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [ACC_W:0] v);
    logic signed [ACC_W:0] hi;
    logic signed [ACC_W:0] lo;
    hi = (ACC_W+1)'($signed(32'h7fff_ffff));
    lo = (ACC_W+1)'($signed(32'h8000_0000));
    if (v > hi) return 32'sh7fff_ffff;
    if (v < lo) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Round half up by sh bits, then saturate.
  function automatic logic signed [31:0] rnd_sat(input logic signed [ACC_W-1:0] v,
                                                 input int sh);
    logic signed [ACC_W:0] t;
    t = (ACC_W+1)'(v);
    t = t + ((ACC_W+1)'(1) <<< (sh - 1));
    t = t >>> sh;
    return sat32(t);
  endfunction

  // Input sample to internal Q8.24.
  function automatic logic signed [31:0] to_internal(
      input logic signed [SAMPLE_WIDTH-1:0] s);
    localparam int UP_SH = (SAMPLE_WIDTH - 1 <= INT_FRAC) ? (INT_FRAC + 1 - SAMPLE_WIDTH) : 0;
    localparam int DN_SH = (SAMPLE_WIDTH - 1 > INT_FRAC) ? (SAMPLE_WIDTH - 1 - INT_FRAC) : 0;
    logic signed [33:0] v;
    v = 34'(s);
    v = v <<< UP_SH;
    if (DN_SH > 0) begin
      v = (v + (34'(1) <<< (DN_SH - 1))) >>> DN_SH;
    end
    return v[31:0];
  endfunction

  // Internal value to output sample, clipped to plus or minus one.
  function automatic logic [SAMPLE_WIDTH-1:0] to_output(input logic signed [31:0] q);
    localparam int SF    = SAMPLE_WIDTH - 1;
    localparam int UP_SH = (SF >= INT_FRAC) ? (SF - INT_FRAC) : 0;
    localparam int DN_SH = (SF < INT_FRAC) ? (INT_FRAC - SF) : 0;
    logic signed [33:0] v;
    logic signed [33:0] one;
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    one = 34'sd1 <<< INT_FRAC;
    hi  = (34'sd1 <<< SF) - 34'sd1;
    lo  = -(34'sd1 <<< SF);
    v   = 34'(q);
    if (v > one) v = one;
    if (v < -one) v = -one;
    v = v <<< UP_SH;
    if (DN_SH > 0) begin
      v = (v + (34'(1) <<< (DN_SH - 1))) >>> DN_SH;
    end
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[SAMPLE_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/sfc_in_if.sv
`default_nettype none

// Input channel: one stereo sample pair per transfer.
interface sfc_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [sfc_pkg::SAMPLE_WIDTH-1:0] left_sample;
  logic signed [sfc_pkg::SAMPLE_WIDTH-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

`default_nettype wire

FILE: hdl/sfc_out_if.sv
`default_nettype none

// Output channel: one stereo result pair per transfer.
interface sfc_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [sfc_pkg::SAMPLE_WIDTH-1:0] left_out;
  logic signed [sfc_pkg::SAMPLE_WIDTH-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

FILE: hdl/stereo_slew_emphasis_filter_chain.sv
// Processing: with a zero wet amount each sample goes straight to output; otherwise each
// channel runs its active stages and then the final stage, left channel before right.
// Throughput: a new pair is taken only once the last result is loaded; a single shared
// multiplier and one state memory port carry every product and history access in turn.
// Reset: asynchronous, active low; clears configuration, control and history to zero.
`default_nettype none

module stereo_slew_emphasis_filter_chain (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sfc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [sfc_pkg::CFG_W-1:0]     cfg_data_i,
  sfc_in_if.sink                             in_i,
  sfc_out_if.source                          out_o
);

  sfc_pkg::sfc_cmd_t cmd;
  sfc_pkg::sfc_sts_t sts;

  // Sequencer.
  sfc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Arithmetic, configuration and state memory.
  sfc_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .left_sample_i  (in_i.left_sample),
    .right_sample_i (in_i.right_sample),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .left_out_o     (out_o.left_out),
    .right_out_o    (out_o.right_out)
  );

endmodule

`default_nettype wire

FILE: hdl/sfc_datapath.sv
`default_nettype none

module sfc_datapath (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    cfg_we_i,
  input  wire logic [sfc_pkg::CFG_IDX_W-1:0]           cfg_idx_i,
  input  wire logic [sfc_pkg::CFG_W-1:0]               cfg_data_i,
  input  wire logic signed [sfc_pkg::SAMPLE_WIDTH-1:0] left_sample_i,
  input  wire logic signed [sfc_pkg::SAMPLE_WIDTH-1:0] right_sample_i,
  input  wire sfc_pkg::sfc_cmd_t                       cmd_i,
  output sfc_pkg::sfc_sts_t                            sts_o,
  output logic signed [sfc_pkg::SAMPLE_WIDTH-1:0]      left_out_o,
  output logic signed [sfc_pkg::SAMPLE_WIDTH-1:0]      right_out_o
);

  logic [sfc_pkg::CFG_W-1:0]               coeff_q [4];
  logic [sfc_pkg::WET_W-1:0]               wamt_q;
  logic signed [sfc_pkg::SAMPLE_WIDTH-1:0] smp_l_q, smp_r_q;
  logic signed [31:0]                      x_q, hold0_q, hold2_q, y_q, wet_q, rd_q;
  logic signed [sfc_pkg::P_W-1:0]          prod_q;
  logic signed [sfc_pkg::ACC_W-1:0]        acc_q, acc_d;
  logic [sfc_pkg::SAMPLE_WIDTH-1:0]        lft_q, out_l_q, out_r_q;
  logic [31:0]                             mem [sfc_pkg::MEM_DEPTH];
  logic [sfc_pkg::MEM_DEPTH-1:0]           vld_q;

  logic [sfc_pkg::AMT_W-1:0]               amt_a, amt_b, amt_c, amt;
  logic [sfc_pkg::CFG_W-1:0]               coeff;
  logic signed [sfc_pkg::MB_W-1:0]         b0, a1, a2;
  logic signed [sfc_pkg::MA_W-1:0]         mul_a;
  logic signed [sfc_pkg::MB_W-1:0]         mul_b;
  logic signed [sfc_pkg::P_W-1:0]          term;
  logic signed [sfc_pkg::ACC_W-1:0]        term_x;
  logic signed [31:0]                      wr_data;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) coeff_q[i] <= '0;
      wamt_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sfc_pkg::REG_STAGE_A: coeff_q[0] <= cfg_data_i & sfc_pkg::COEFF_MASK;
        sfc_pkg::REG_STAGE_B: coeff_q[1] <= cfg_data_i & sfc_pkg::COEFF_MASK;
        sfc_pkg::REG_STAGE_C: coeff_q[2] <= cfg_data_i & sfc_pkg::COEFF_MASK;
        sfc_pkg::REG_FINAL:   coeff_q[3] <= cfg_data_i & sfc_pkg::COEFF_MASK;
        sfc_pkg::REG_WET:     wamt_q <= cfg_data_i[sfc_pkg::WET_W-1:0];
        default: ;
      endcase
    end
  end

  // Split the wet control into the three stage amounts.
  always_comb begin
    if (wamt_q < sfc_pkg::WET_W'(sfc_pkg::AMT_ONE)) begin
      amt_a = wamt_q[sfc_pkg::AMT_W-1:0];
      amt_b = '0;
      amt_c = '0;
    end else if (wamt_q < (sfc_pkg::WET_W'(sfc_pkg::AMT_ONE) << 1)) begin
      amt_a = sfc_pkg::AMT_ONE;
      amt_b = sfc_pkg::AMT_W'(wamt_q - sfc_pkg::WET_W'(sfc_pkg::AMT_ONE));
      amt_c = '0;
    end else begin
      amt_a = sfc_pkg::AMT_ONE;
      amt_b = sfc_pkg::AMT_ONE;
      if (wamt_q - (sfc_pkg::WET_W'(sfc_pkg::AMT_ONE) << 1) > sfc_pkg::WET_W'(sfc_pkg::AMT_ONE))
        amt_c = sfc_pkg::AMT_ONE;
      else
        amt_c = sfc_pkg::AMT_W'(wamt_q - (sfc_pkg::WET_W'(sfc_pkg::AMT_ONE) << 1));
    end
  end

  assign sts_o.a_nz = (amt_a != '0);
  assign sts_o.b_nz = (amt_b != '0);
  assign sts_o.c_nz = (amt_c != '0);

  // Coefficients and amount of the stage at work.
  always_comb begin
    unique case (cmd_i.stage)
      sfc_pkg::STG_B: amt = amt_b;
      sfc_pkg::STG_C: amt = amt_c;
      default:        amt = amt_a;
    endcase
    coeff = coeff_q[cmd_i.stage];
    b0 = sfc_pkg::MB_W'($signed(coeff[0 +: sfc_pkg::COEFF_WIDTH]));
    a1 = sfc_pkg::MB_W'($signed(coeff[sfc_pkg::COEFF_WIDTH +: sfc_pkg::COEFF_WIDTH]));
    a2 = sfc_pkg::MB_W'($signed(coeff[2*sfc_pkg::COEFF_WIDTH +: sfc_pkg::COEFF_WIDTH]));
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (cmd_i.mul_op)
      sfc_pkg::OP_B0X: begin
        mul_a = sfc_pkg::MA_W'(x_q);
        mul_b = b0;
      end
      sfc_pkg::OP_HB0: begin
        mul_a = sfc_pkg::MA_W'(rd_q);
        mul_b = b0;
      end
      sfc_pkg::OP_HA1: begin
        mul_a = sfc_pkg::MA_W'(rd_q);
        mul_b = a1;
      end
      sfc_pkg::OP_HA2: begin
        mul_a = sfc_pkg::MA_W'(rd_q);
        mul_b = a2;
      end
      sfc_pkg::OP_SLEW: begin
        mul_a = sfc_pkg::MA_W'(y_q) - sfc_pkg::MA_W'(rd_q);
        mul_b = sfc_pkg::LN10_Q28;
      end
      sfc_pkg::OP_WET: begin
        mul_a = sfc_pkg::MA_W'(wet_q);
        mul_b = sfc_pkg::MB_W'($signed({1'b0, amt}));
      end
      default: begin
        mul_a = sfc_pkg::MA_W'(x_q);
        mul_b = sfc_pkg::MB_W'($signed({1'b0, sfc_pkg::AMT_ONE - amt}));
      end
    endcase
  end

  // Accumulator update from the registered product.
  always_comb begin
    term   = cmd_i.guard ? (prod_q >>> sfc_pkg::GUARD) : prod_q;
    term_x = sfc_pkg::ACC_W'(term);
    unique case (cmd_i.acc_mode)
      sfc_pkg::ACC_LOAD: acc_d = term_x;
      sfc_pkg::ACC_ADD:  acc_d = acc_q + term_x;
      sfc_pkg::ACC_ADD2: acc_d = acc_q + (term_x <<< 1);
      default:           acc_d = acc_q - term_x;
    endcase
  end

  // Arithmetic and working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      smp_l_q <= left_sample_i;
      smp_r_q <= right_sample_i;
    end
    if (cmd_i.mul_en) prod_q <= mul_a * mul_b;
    if (cmd_i.acc_en) acc_q <= acc_d;
    if (cmd_i.hold0_en) hold0_q <= rd_q;
    if (cmd_i.hold2_en) hold2_q <= rd_q;
    if (cmd_i.y_en) begin
      y_q   <= sfc_pkg::rnd_sat(acc_q, sfc_pkg::BQ_SHIFT);
      wet_q <= sfc_pkg::rnd_sat(acc_q, sfc_pkg::BQ_SHIFT);
    end else if (cmd_i.slew_en) begin
      wet_q <= sfc_pkg::rnd_sat(sfc_pkg::ACC_W'(prod_q), 28);
    end
    if (cmd_i.x_load) begin
      x_q <= sfc_pkg::to_internal(cmd_i.ch ? smp_r_q : smp_l_q);
    end else if (cmd_i.x_en) begin
      x_q <= sfc_pkg::rnd_sat(acc_q, 16);
    end
    if (cmd_i.lft_en) lft_q <= sfc_pkg::to_output(x_q);
    if (cmd_i.out_load) begin
      out_l_q <= lft_q;
      out_r_q <= sfc_pkg::to_output(x_q);
    end
  end

  // State memory write data.
  always_comb begin
    unique case (cmd_i.wr_sel)
      sfc_pkg::WR_HOLD0: wr_data = hold0_q;
      sfc_pkg::WR_X:     wr_data = x_q;
      sfc_pkg::WR_HOLD2: wr_data = hold2_q;
      default:           wr_data = y_q;
    endcase
  end

  // State memory with registered read; unwritten entries read as zero.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem[cmd_i.wr_addr] <= wr_data;
    if (cmd_i.rd_en) rd_q <= vld_q[cmd_i.rd_addr] ? $signed(mem[cmd_i.rd_addr]) : 32'sd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.wr_en) begin
      vld_q[cmd_i.wr_addr] <= 1'b1;
    end
  end

  assign left_out_o  = $signed(out_l_q);
  assign right_out_o = $signed(out_r_q);

endmodule

`default_nettype wire

FILE: hdl/sfc_ctrl.sv
`default_nettype none

module sfc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire sfc_pkg::sfc_sts_t sts_i,
  output sfc_pkg::sfc_cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_XF   = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  // Micro-operations of one stage.
  localparam logic [3:0] U_B0X  = 4'd0;
  localparam logic [3:0] U_H0   = 4'd1;
  localparam logic [3:0] U_H1   = 4'd2;
  localparam logic [3:0] U_A1   = 4'd3;
  localparam logic [3:0] U_A2   = 4'd4;
  localparam logic [3:0] U_SLEW = 4'd6;
  localparam logic [3:0] U_WET  = 4'd7;
  localparam logic [3:0] U_DRY  = 4'd8;

  // History slots: x[n-1], x[n-2], y[n-1], y[n-2].
  localparam logic [1:0] K_X1 = 2'd0;
  localparam logic [1:0] K_X2 = 2'd1;
  localparam logic [1:0] K_Y1 = 2'd2;
  localparam logic [1:0] K_Y2 = 2'd3;

  logic [2:0] state_q, state_d;
  logic [3:0] uop_q, uop_d;
  logic [1:0] wcnt_q, wcnt_d;
  logic [1:0] stage_q, stage_d;
  logic       ch_q, ch_d;
  logic       outv_q, outv_d;

  function automatic logic [sfc_pkg::ADDR_W-1:0] hist_addr(input logic [1:0] stg,
                                                           input logic c,
                                                           input logic [1:0] k);
    return {1'b0, stg, c, k};
  endfunction

  function automatic logic [sfc_pkg::ADDR_W-1:0] slew_addr(input logic [1:0] stg,
                                                           input logic c);
    return {1'b1, 2'b00, stg, c};
  endfunction

  // Sequencer: biquad products, history update, slew, crossfade.
  always_comb begin
    state_d = state_q;
    uop_d   = uop_q;
    wcnt_d  = wcnt_q;
    stage_d = stage_q;
    ch_d    = ch_q;
    outv_d  = outv_q;
    cmd_o   = '0;
    cmd_o.ch       = ch_q;
    cmd_o.stage    = stage_q;
    cmd_o.mul_op   = sfc_pkg::OP_B0X;
    cmd_o.acc_mode = sfc_pkg::ACC_LOAD;
    cmd_o.wr_sel   = sfc_pkg::WR_HOLD0;

    if (outv_q && out_ready_i) outv_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          ch_d    = 1'b0;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.x_load = 1'b1;
        if (sts_i.a_nz) begin
          stage_d = sfc_pkg::STG_A;
          uop_d   = U_B0X;
          state_d = S_MUL;
        end else begin
          state_d = S_OUT;
        end
      end
      S_MUL: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.hold0_en = (uop_q == U_H0);
        cmd_o.hold2_en = (uop_q == U_A1);
        unique case (uop_q)
          U_B0X:       cmd_o.mul_op = sfc_pkg::OP_B0X;
          U_H0, U_H1:  cmd_o.mul_op = sfc_pkg::OP_HB0;
          U_A1:        cmd_o.mul_op = sfc_pkg::OP_HA1;
          U_A2:        cmd_o.mul_op = sfc_pkg::OP_HA2;
          U_SLEW:      cmd_o.mul_op = sfc_pkg::OP_SLEW;
          U_WET:       cmd_o.mul_op = sfc_pkg::OP_WET;
          default:     cmd_o.mul_op = sfc_pkg::OP_DRY;
        endcase
        state_d = S_ACC;
      end
      S_ACC: begin
        // Fetch the history entry for the next product.
        if (uop_q < U_A2) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = hist_addr(stage_q, ch_q, uop_q[1:0]);
        end
        state_d = S_MUL;
        uop_d   = uop_q + 4'd1;
        unique case (uop_q)
          U_B0X: begin
            cmd_o.acc_en = 1'b1;
            cmd_o.guard  = 1'b1;
          end
          U_H0: begin
            cmd_o.acc_en   = 1'b1;
            cmd_o.guard    = 1'b1;
            cmd_o.acc_mode = sfc_pkg::ACC_ADD2;
          end
          U_H1: begin
            cmd_o.acc_en   = 1'b1;
            cmd_o.guard    = 1'b1;
            cmd_o.acc_mode = sfc_pkg::ACC_ADD;
          end
          U_A1: begin
            cmd_o.acc_en   = 1'b1;
            cmd_o.guard    = 1'b1;
            cmd_o.acc_mode = sfc_pkg::ACC_SUB;
          end
          U_A2: begin
            cmd_o.acc_en   = 1'b1;
            cmd_o.guard    = 1'b1;
            cmd_o.acc_mode = sfc_pkg::ACC_SUB;
            wcnt_d  = 2'd0;
            state_d = S_WR;
          end
          U_SLEW: begin
            cmd_o.slew_en = 1'b1;
            cmd_o.wr_en   = 1'b1;
            cmd_o.wr_addr = slew_addr(stage_q, ch_q);
            cmd_o.wr_sel  = sfc_pkg::WR_Y;
          end
          U_WET: begin
            cmd_o.acc_en = 1'b1;
          end
          U_DRY: begin
            cmd_o.acc_en   = 1'b1;
            cmd_o.acc_mode = sfc_pkg::ACC_ADD;
            state_d = S_XF;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_WR: begin
        // Shift the biquad history, one entry a cycle.
        cmd_o.wr_en = 1'b1;
        wcnt_d = wcnt_q + 2'd1;
        unique case (wcnt_q)
          2'd0: begin
            cmd_o.y_en    = 1'b1;
            cmd_o.wr_addr = hist_addr(stage_q, ch_q, K_X2);
            cmd_o.wr_sel  = sfc_pkg::WR_HOLD0;
          end
          2'd1: begin
            cmd_o.wr_addr = hist_addr(stage_q, ch_q, K_X1);
            cmd_o.wr_sel  = sfc_pkg::WR_X;
          end
          2'd2: begin
            cmd_o.wr_addr = hist_addr(stage_q, ch_q, K_Y2);
            cmd_o.wr_sel  = sfc_pkg::WR_HOLD2;
          end
          default: begin
            cmd_o.wr_addr = hist_addr(stage_q, ch_q, K_Y1);
            cmd_o.wr_sel  = sfc_pkg::WR_Y;
            state_d = S_MUL;
            if (stage_q != sfc_pkg::STG_D) begin
              cmd_o.rd_en   = 1'b1;
              cmd_o.rd_addr = slew_addr(stage_q, ch_q);
              uop_d = U_SLEW;
            end else begin
              uop_d = U_WET;
            end
          end
        endcase
      end
      S_XF: begin
        cmd_o.x_en = 1'b1;
        uop_d   = U_B0X;
        state_d = S_MUL;
        unique case (stage_q)
          sfc_pkg::STG_A: stage_d = sts_i.b_nz ? sfc_pkg::STG_B : sfc_pkg::STG_D;
          sfc_pkg::STG_B: stage_d = sts_i.c_nz ? sfc_pkg::STG_C : sfc_pkg::STG_D;
          sfc_pkg::STG_C: stage_d = sfc_pkg::STG_D;
          default:        state_d = S_OUT;
        endcase
      end
      S_OUT: begin
        if (!ch_q) begin
          cmd_o.lft_en = 1'b1;
          ch_d    = 1'b1;
          state_d = S_LOAD;
        end else if (!outv_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          outv_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      uop_q   <= U_B0X;
      wcnt_q  <= 2'd0;
      stage_q <= sfc_pkg::STG_A;
      ch_q    <= 1'b0;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      uop_q   <= uop_d;
      wcnt_q  <= wcnt_d;
      stage_q <= stage_d;
      ch_q    <= ch_d;
      outv_q  <= outv_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = outv_q;

  // An accepted pair starts with loading the left channel.
  a_accept_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_LOAD && !ch_q))
    else $error("accepted pair did not start loading");

  // The state memory is written only while shifting history or storing the slew.
  a_wr_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_en |-> (state_q == S_WR || (state_q == S_ACC && uop_q == U_SLEW)))
    else $error("state memory written outside its phases");

  // Stages only move forward within a channel.
  a_stage_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_XF && stage_q != sfc_pkg::STG_D) |=> (stage_q > $past(stage_q)))
    else $error("stage did not advance");

  // A result becomes valid only after the right channel is finished.
  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(outv_q) |-> $past(state_q == S_OUT && ch_q))
    else $error("result valid without finished pair");

endmodule

`default_nettype wire

FILE: dv/sfc_chk.sv
`timescale 1ns / 100ps
`default_nettype none

// Watches both channels, predicts each stereo result and compares it.
module sfc_chk (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sfc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [sfc_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_ready_i,
  input  wire logic [23:0]                   in_left_i,
  input  wire logic [23:0]                   in_right_i,
  input  wire logic                          out_valid_i,
  input  wire logic                          out_ready_i,
  input  wire logic [23:0]                   out_left_i,
  input  wire logic [23:0]                   out_right_i,
  output logic [31:0]                        fail_count_o,
  output logic [31:0]                        pending_o
);

  localparam longint LN10 = 618095479;
  localparam longint ONE_AMT = 65536;

  // Model copy of the configuration and filter state.
  logic [sfc_pkg::CFG_W-1:0] coeff_q [4];
  logic [17:0]               wet_q;
  longint                    hist_q [32];
  longint                    slew_q [6];
  logic [47:0]               pair_q [$];

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_by(input longint v, input int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint coeff_of(input int stg, input int i);
    logic signed [17:0] f;
    f = coeff_q[stg][i*18 +: 18];
    return longint'(f);
  endfunction

  function automatic longint biquad(input int stg, input int ch, input longint x);
    int     b;
    longint b0, acc, y;
    b   = stg * 8 + ch * 4;
    b0  = coeff_of(stg, 0);
    acc = b0 * x + 2 * (b0 * hist_q[b]) + b0 * hist_q[b+1]
        - coeff_of(stg, 1) * hist_q[b+2] - coeff_of(stg, 2) * hist_q[b+3];
    y = clamp32(round_by(acc, 16));
    hist_q[b+1] = hist_q[b];
    hist_q[b]   = x;
    hist_q[b+3] = hist_q[b+2];
    hist_q[b+2] = y;
    return y;
  endfunction

  function automatic longint slew(input int stg, input int ch, input longint s);
    longint d;
    d = s - slew_q[stg*2+ch];
    slew_q[stg*2+ch] = s;
    return clamp32(round_by(d * LN10, 28));
  endfunction

  function automatic longint blend(input longint wet, input longint dry, input longint amt);
    return clamp32(round_by(wet * amt + dry * (ONE_AMT - amt), 16));
  endfunction

  function automatic logic [23:0] out_code(input longint v);
    if (v > (64'sd1 <<< 24)) v = 64'sd1 <<< 24;
    if (v < -(64'sd1 <<< 24)) v = -(64'sd1 <<< 24);
    v = round_by(v, 1);
    if (v > 64'sd8388607) v = 64'sd8388607;
    return v[23:0];
  endfunction

  // Run one stereo pair through the chain and return {left, right}.
  function automatic logic [47:0] filter_pair(input logic [23:0] l, input logic [23:0] r);
    longint w, am_a, am_b, am_c, x, sa, sb;
    logic signed [23:0] smp;
    logic [23:0] res [2];
    w = longint'(wet_q);
    if (w < ONE_AMT) begin
      am_a = w; am_b = 0; am_c = 0;
    end else if (w < 2 * ONE_AMT) begin
      am_a = ONE_AMT; am_b = w - ONE_AMT; am_c = 0;
    end else begin
      am_a = ONE_AMT; am_b = ONE_AMT; am_c = w - 2 * ONE_AMT;
      if (am_c > ONE_AMT) am_c = ONE_AMT;
    end
    for (int ch = 0; ch < 2; ch++) begin
      smp = (ch == 0) ? l : r;
      x = longint'(smp) * 2;
      sa = 0; sb = 0;
      if (am_a > 0) begin
        x = blend(slew(0, ch, biquad(0, ch, x)), x, am_a); sa = x;
      end
      if (am_b > 0) begin
        x = blend(slew(1, ch, biquad(1, ch, x)), sa, am_b); sb = x;
      end
      if (am_c > 0) x = blend(slew(2, ch, biquad(2, ch, x)), sb, am_c);
      if (am_a > 0) x = blend(biquad(3, ch, x), x, am_a);
      res[ch] = out_code(x);
    end
    return {res[0], res[1]};
  endfunction

  // Track configuration writes, input transfers and output transfers.
  always @(posedge clk_i or negedge rst_ni) begin
    logic [47:0] exp_pair;
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) coeff_q[i] = '0;
      for (int i = 0; i < 32; i++) hist_q[i] = 0;
      for (int i = 0; i < 6; i++) slew_q[i] = 0;
      wet_q = '0;
      pair_q.delete();
      fail_count_o <= 0;
      pending_o <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i < sfc_pkg::REG_WET) coeff_q[cfg_idx_i[1:0]] = cfg_data_i;
        else if (cfg_idx_i == sfc_pkg::REG_WET) wet_q = cfg_data_i[17:0];
      end
      if (in_valid_i && in_ready_i) pair_q.push_back(filter_pair(in_left_i, in_right_i));
      if (out_valid_i && out_ready_i) begin
        if (pair_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result %h %h", out_left_i, out_right_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_pair = pair_q.pop_front();
          if (exp_pair != {out_left_i, out_right_i}) begin
            if (fail_count_o < 10)
              $display("mismatch: expected L %h R %h, got L %h R %h",
                       exp_pair[47:24], exp_pair[23:0], out_left_i, out_right_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= 32'(pair_q.size());
    end
  end

endmodule

`default_nettype wire

FILE: dv/tb_stereo_slew_emphasis_filter_chain.sv
`timescale 1ns / 100ps
`default_nettype none

module tb_stereo_slew_emphasis_filter_chain;

  // Register index past the end of the list; writes to it are ignored.
  localparam logic [sfc_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [sfc_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [sfc_pkg::CFG_W-1:0]     cfg_data_i = '0;
  logic                          sink_ready = 1'b0;
  logic [31:0]                   fail_count;
  logic [31:0]                   pending;

  sfc_in_if  in_ch ();
  sfc_out_if out_ch ();

  stereo_slew_emphasis_filter_chain dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  sfc_chk chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_valid_i(in_ch.valid), .in_ready_i(in_ch.ready),
    .in_left_i(in_ch.left_sample), .in_right_i(in_ch.right_sample),
    .out_valid_i(out_ch.valid), .out_ready_i(out_ch.ready),
    .out_left_i(out_ch.left_out), .out_right_i(out_ch.right_out),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  assign out_ch.ready = sink_ready;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.left_sample = '0;
    in_ch.right_sample = '0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  // Result side stalls at random; in about one block of four, chosen at random, it never stalls.
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 3) == 0) begin
        sink_ready <= 1'b1;
        repeat ($urandom_range(50, 400)) @(posedge clk_i);
      end else begin
        n = gap_len();
        sink_ready <= (n == 0);
        repeat (n) @(posedge clk_i);
        sink_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [sfc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sfc_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // One pair transfer; the sender may idle before it.
  task automatic send_pair(input logic [23:0] l, input logic [23:0] r, input bit no_gap);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      @(posedge clk_i);
      in_ch.valid <= 1'b0;
      repeat (g - 1) @(posedge clk_i);
    end
    @(posedge clk_i);
    in_ch.valid        <= 1'b1;
    in_ch.left_sample  <= l;
    in_ch.right_sample <= r;
    do @(posedge clk_i); while (!in_ch.ready);
    in_ch.valid <= 1'b0;
  endtask

  // Let the last transfer be counted, then wait until all results are back.
  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // Stable lowpass-like coefficients with random content, or fully random fields.
  function automatic logic [sfc_pkg::CFG_W-1:0] rand_coeffs(input bit wild);
    logic [17:0] b0, a1, a2;
    if (wild) return sfc_pkg::CFG_W'({$urandom, $urandom});
    b0 = 18'($urandom_range(0, 16384));
    a1 = -18'sd65536 + 18'($urandom_range(0, 98304));
    a2 = 18'($urandom_range(0, 50000));
    return {a2, a1, b0};
  endfunction

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 24'h7fffff;
      1: return 24'h800000;
      default: return 24'($urandom);
    endcase
  endfunction

  localparam logic [17:0] WET_SET [8] = '{18'd0, 18'd1, 18'd32768, 18'd65536,
                                          18'd100000, 18'd131072, 18'd170000, 18'd196608};

  initial begin
    logic [23:0] edge_val [6];
    edge_val = '{24'h7fffff, 24'h800000, 24'h000000, 24'h000001, 24'hffffff, 24'h400000};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero wet (bypass); full wet, extreme coefficients in stages A and B; wet just under one.
    for (int i = 0; i < 6; i++) send_pair(edge_val[i], edge_val[5 - i], 1'b0);
    drain();
    write_reg(sfc_pkg::REG_STAGE_A, {18'h1ffff, 18'h20000, 18'h1ffff});
    write_reg(sfc_pkg::REG_STAGE_B, {18'h20000, 18'h1ffff, 18'h20000});
    write_reg(sfc_pkg::REG_STAGE_C, rand_coeffs(1'b0));
    write_reg(sfc_pkg::REG_FINAL, {18'h00000, 18'h00000, 18'h10000});
    write_reg(sfc_pkg::REG_WET, sfc_pkg::CFG_W'(18'h3ffff));
    for (int i = 0; i < 6; i++) send_pair(edge_val[i], edge_val[i], 1'b1);
    drain();
    write_reg(REG_NONE, sfc_pkg::CFG_W'({$urandom, $urandom}));
    write_reg(sfc_pkg::REG_WET, sfc_pkg::CFG_W'(18'd65535));
    for (int i = 0; i < 6; i++) send_pair(edge_val[5 - i], edge_val[i], 1'b0);
    drain();

    // Random phases over several settings.
    for (int ph = 0; ph < 23; ph++) begin
      for (int k = 0; k < 4; k++)
        write_reg(sfc_pkg::CFG_IDX_W'(k), rand_coeffs($urandom_range(0, 4) == 0));
      write_reg(sfc_pkg::REG_WET,
                sfc_pkg::CFG_W'((ph < 8) ? WET_SET[ph] : 18'($urandom_range(0, 262143))));
      for (int i = 0; i < 50; i++) send_pair(rand_sample(), rand_sample(), 1'b0);
      drain();
    end

    if (fail_count == 0) begin
      $display("tb_stereo_slew_emphasis_filter_chain OK");
    end else begin
      $display("tb_stereo_slew_emphasis_filter_chain NOT OK");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("tb_stereo_slew_emphasis_filter_chain NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
hdl/sfc_pkg.sv
hdl/sfc_in_if.sv
hdl/sfc_out_if.sv
hdl/sfc_datapath.sv
hdl/sfc_ctrl.sv
hdl/stereo_slew_emphasis_filter_chain.sv
dv/sfc_chk.sv
dv/tb_stereo_slew_emphasis_filter_chain.sv
